// ===== rtl/flc_pkg.sv =====
// Shared types, codes and sizes for the lock coordinator.
package flc_pkg;

    // Default queue depth
    localparam int FLC_QUEUE_DEPTH = 16;

    localparam int NODE_W    = 8;
    localparam int STALL_W   = 8;
    localparam int TOTAL_W   = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [STALL_W-1:0] STALL_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_OUTAGE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic [STALL_W-1:0] TIMEOUT_RESET = 8'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_NONE    = 2'd3
    } flc_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_FULL     = 2'd2
    } flc_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } flc_state_t;

endpackage

// ===== rtl/fifo_lock_coordinator.sv =====
// Top level: FIFO lock coordinator with the node queue held in a RAM.
// Results: each result beat is registered from its input beat; when a release or
//   eviction pops the head and the queue still holds nodes, the new head is first read
//   from the queue RAM (registered read port) in ST_FETCH before it can be granted.
// Throughput: one beat per cycle while m_tready is high, except during ST_FETCH.
// Reset: control, pointers and counters clear; the queue RAM is not cleared.
module fifo_lock_coordinator
    import flc_pkg::*;
#(
    parameter int QUEUE_DEPTH = FLC_QUEUE_DEPTH,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_BITS = 2 * NODE_W + 2 * CNT_W + 2 * TOTAL_W,
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [NODE_W-1:0]     s_tdata,   // node_id
    input  logic [CMD_W-1:0]      s_tuser,   // command
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // grant_node, evicted_node, queue_count, admitted_total, peak_queue, failed_total
    output logic [OUT_W-1:0]      m_tdata,
    output logic [3:0]            m_tuser,   // grant_valid, status[1:0], evicted_valid
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Control state
    flc_state_t state_reg, state_next;

    logic [PTR_W-1:0]   head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]   tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [NODE_W-1:0]  head_node_reg, head_node_next;
    logic               watch_valid_reg, watch_valid_next;
    logic [NODE_W-1:0]  watch_node_reg, watch_node_next;
    logic [STALL_W-1:0] stall_reg, stall_next;
    logic [TOTAL_W-1:0] admitted_reg, admitted_next;
    logic [CNT_W-1:0]   peak_reg, peak_next;
    logic [TOTAL_W-1:0] failed_reg, failed_next;
    logic               outage_en_reg;
    logic [STALL_W-1:0] timeout_reg;

    // Eviction details held while the new head is fetched
    logic               pend_evict_reg, pend_evict_next;
    logic [NODE_W-1:0]  pend_enode_reg, pend_enode_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_grant_reg, out_grant_next;
    logic [NODE_W-1:0]  out_gnode_reg, out_gnode_next;
    flc_status_t        out_status_reg, out_status_next;
    logic               out_evict_reg, out_evict_next;
    logic [NODE_W-1:0]  out_enode_reg, out_enode_next;
    logic               out_load;

    // Queue RAM ports
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [NODE_W-1:0]  ram_rd_data;

    logic               accept;
    logic               pop_fetch;
    flc_cmd_t           cmd;
    logic [NODE_W-1:0]  node_in;
    logic [CNT_W-1:0]   count_pop;
    logic [PTR_W-1:0]   head_ptr_inc;
    logic [PTR_W-1:0]   tail_ptr_inc;
    logic [STALL_W-1:0] stall_tick;

    assign cmd     = flc_cmd_t'(s_tuser);
    assign node_in = s_tdata;

    // Take a new item only when idle and the output register frees up this cycle
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign count_pop    = count_reg - CNT_ONE;
    assign head_ptr_inc = (head_ptr_reg == PTR_LAST) ? '0 : head_ptr_reg + PTR_W'(1);
    assign tail_ptr_inc = (tail_ptr_reg == PTR_LAST) ? '0 : tail_ptr_reg + PTR_W'(1);

    flc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_ptr_reg),
        .wr_data (node_in),
        .rd_en   (ram_rd_en),
        .rd_addr (head_ptr_next),
        .rd_data (ram_rd_data)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && pop_fetch)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic
    always_comb
    begin
        head_ptr_next    = head_ptr_reg;
        tail_ptr_next    = tail_ptr_reg;
        count_next       = count_reg;
        head_node_next   = head_node_reg;
        watch_valid_next = watch_valid_reg;
        watch_node_next  = watch_node_reg;
        stall_next       = stall_reg;
        admitted_next    = admitted_reg;
        peak_next        = peak_reg;
        failed_next      = failed_reg;
        pend_evict_next  = pend_evict_reg;
        pend_enode_next  = pend_enode_reg;

        out_load        = 1'b0;
        out_grant_next  = 1'b0;
        out_gnode_next  = '0;
        out_status_next = STATUS_OK;
        out_evict_next  = 1'b0;
        out_enode_next  = '0;

        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;
        pop_fetch  = 1'b0;
        stall_tick = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_REQUEST:
                        begin
                            out_load = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                // Queue full: drop the node
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_wr_en     = 1'b1;
                                tail_ptr_next = tail_ptr_inc;
                                count_next    = count_reg + CNT_ONE;
                                if (count_reg == '0)
                                begin
                                    // First node in an empty queue takes the lock
                                    head_node_next = node_in;
                                    out_grant_next = 1'b1;
                                    out_gnode_next = node_in;
                                    admitted_next  = admitted_reg + TOTAL_W'(1);
                                    if (CNT_ONE > peak_reg)
                                    begin
                                        peak_next = CNT_ONE;
                                    end
                                end
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (count_reg == '0 || head_node_reg != node_in)
                            begin
                                out_load        = 1'b1;
                                out_status_next = STATUS_MISMATCH;
                            end
                            else
                            begin
                                head_ptr_next   = head_ptr_inc;
                                count_next      = count_pop;
                                pend_evict_next = 1'b0;
                                if (count_pop != '0)
                                begin
                                    // Fetch the next head before answering
                                    pop_fetch = 1'b1;
                                    ram_rd_en = 1'b1;
                                end
                                else
                                begin
                                    out_load = 1'b1;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (outage_en_reg && count_reg != '0)
                            begin
                                if (watch_valid_reg && watch_node_reg == head_node_reg)
                                begin
                                    stall_tick = (stall_reg != STALL_MAX) ?
                                                 stall_reg + STALL_W'(1) : stall_reg;
                                end
                                else
                                begin
                                    stall_tick = '0;
                                end
                                watch_valid_next = 1'b1;
                                watch_node_next  = head_node_reg;
                                stall_next       = stall_tick;
                                if (stall_tick == timeout_reg)
                                begin
                                    // Evict the stalled head and forget it
                                    failed_next      = failed_reg + TOTAL_W'(1);
                                    head_ptr_next    = head_ptr_inc;
                                    count_next       = count_pop;
                                    watch_valid_next = 1'b0;
                                    stall_next       = '0;
                                    pend_evict_next  = 1'b1;
                                    pend_enode_next  = head_node_reg;
                                    if (count_pop != '0)
                                    begin
                                        pop_fetch = 1'b1;
                                        ram_rd_en = 1'b1;
                                    end
                                    else
                                    begin
                                        out_load       = 1'b1;
                                        out_evict_next = 1'b1;
                                        out_enode_next = head_node_reg;
                                    end
                                end
                                else
                                begin
                                    out_load = 1'b1;
                                end
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                // New head arrives from the RAM: grant it
                out_load       = 1'b1;
                head_node_next = ram_rd_data;
                out_grant_next = 1'b1;
                out_gnode_next = ram_rd_data;
                out_evict_next = pend_evict_reg;
                out_enode_next = pend_evict_reg ? pend_enode_reg : '0;
                admitted_next  = admitted_reg + TOTAL_W'(1);
                if (count_reg > peak_reg)
                begin
                    peak_next = count_reg;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_ptr_reg    <= '0;
            tail_ptr_reg    <= '0;
            count_reg       <= '0;
            watch_valid_reg <= 1'b0;
            stall_reg       <= '0;
            admitted_reg    <= '0;
            peak_reg        <= '0;
            failed_reg      <= '0;
            out_valid_reg   <= 1'b0;
            pend_evict_reg  <= 1'b0;
            outage_en_reg   <= 1'b1;
            timeout_reg     <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            head_ptr_reg    <= head_ptr_next;
            tail_ptr_reg    <= tail_ptr_next;
            count_reg       <= count_next;
            watch_valid_reg <= watch_valid_next;
            stall_reg       <= stall_next;
            admitted_reg    <= admitted_next;
            peak_reg        <= peak_next;
            failed_reg      <= failed_next;
            out_valid_reg   <= out_valid_next;
            pend_evict_reg  <= pend_evict_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OUTAGE_ENABLE: outage_en_reg <= cfg_data[0];
                    REG_TIMEOUT_TICKS: timeout_reg   <= cfg_data;
                    default:           timeout_reg   <= timeout_reg;
                endcase
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        head_node_reg  <= head_node_next;
        watch_node_reg <= watch_node_next;
        pend_enode_reg <= pend_enode_next;
        if (out_load)
        begin
            out_grant_reg  <= out_grant_next;
            out_gnode_reg  <= out_gnode_next;
            out_status_reg <= out_status_next;
            out_evict_reg  <= out_evict_next;
            out_enode_reg  <= out_enode_next;
        end
    end

    // Counters in the output beat are the live registers; they hold until the next accept
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_evict_reg, out_status_reg, out_grant_reg};
    assign m_tdata  = OUT_W'({failed_reg, peak_reg, admitted_reg, count_reg,
                              out_enode_reg, out_gnode_reg});

endmodule

// ===== rtl/flc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module flc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the FIFO lock coordinator: directed and random beats.
module testbench
    import flc_pkg::*;
();

    localparam int DEPTH = FLC_QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((2 * NODE_W + 2 * CNT_W + 2 * TOTAL_W + 7) / 8) * 8;

    // Bit offsets of the result fields inside m_tdata, lowest field first
    localparam int EVICT_LSB = NODE_W;
    localparam int COUNT_LSB = 2 * NODE_W;
    localparam int ADMIT_LSB = COUNT_LSB + CNT_W;
    localparam int PEAK_LSB  = ADMIT_LSB + TOTAL_W;
    localparam int FAIL_LSB  = PEAK_LSB + CNT_W;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 116;
    localparam int SETTLE_CYCLES   = 4;      // margin after the last outstanding result
    localparam int DRAIN_LIMIT     = 5000;
    localparam int MAX_REPORTS     = 40;
    localparam int TIMEOUT_NS      = 2_000_000;

    // One expected result beat
    typedef struct packed {
        logic               grant_valid;
        logic [NODE_W-1:0]  grant_node;
        flc_status_t        status;
        logic               evicted_valid;
        logic [NODE_W-1:0]  evicted_node;
        logic [CNT_W-1:0]   queue_count;
        logic [TOTAL_W-1:0] admitted_total;
        logic [CNT_W-1:0]   peak_queue;
        logic [TOTAL_W-1:0] failed_total;
    } lock_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [NODE_W-1:0]     s_tdata = '0;   // node_id
    logic [CMD_W-1:0]      s_tuser = '0;   // command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // grant_node, evicted_node, queue_count, admitted_total, peak_queue, failed_total
    logic [OUT_W-1:0]      m_tdata;
    logic [3:0]            m_tuser;        // grant_valid, status[1:0], evicted_valid
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Idle and stall rates of the current phase, in percent
    int idle_pct  = 0;
    int stall_pct = 0;

    // Long receiver hold-off, requested by a test and counted by the receiver
    logic hold_off_start = 1'b0;
    int   hold_off_left  = 0;

    int mismatch_count = 0;

    // Predicted coordinator state, updated on every accepted input beat
    logic [NODE_W-1:0]  lock_queue [DEPTH];
    logic [PTR_W-1:0]   lock_head = '0;
    logic [PTR_W-1:0]   lock_tail = '0;
    logic [CNT_W-1:0]   lock_count = '0;
    logic               watch_valid = 1'b0;
    logic [NODE_W-1:0]  watch_node = '0;
    logic [STALL_W-1:0] stall_ticks = '0;
    logic [TOTAL_W-1:0] grants_so_far = '0;
    logic [TOTAL_W-1:0] evictions_so_far = '0;
    logic [CNT_W-1:0]   peak_seen = '0;
    logic               outage_on = 1'b1;
    logic [STALL_W-1:0] timeout_limit = TIMEOUT_RESET;

    lock_result_t pending_results[$];

    fifo_lock_coordinator #(.QUEUE_DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lock predictor
    // ------------------------------------------------------------------

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Grant whatever node now sits at the head, if any
    function automatic void grant_new_head(inout lock_result_t r);
        if (lock_count != 0)
        begin
            r.grant_valid = 1'b1;
            r.grant_node  = lock_queue[lock_head];
            grants_so_far = grants_so_far + TOTAL_W'(1);
            if (lock_count > peak_seen)
                peak_seen = lock_count;
        end
    endfunction

    // Advance the predicted state by one command and queue the result it causes
    function automatic void predict_lock_step(input flc_cmd_t cmd,
                                              input logic [NODE_W-1:0] node);
        lock_result_t r;
        logic [NODE_W-1:0] head;
        r = '0;
        r.status = STATUS_OK;
        case (cmd)
            CMD_REQUEST:
            begin
                if (lock_count >= CNT_W'(DEPTH))
                    r.status = STATUS_FULL;
                else
                begin
                    lock_queue[lock_tail] = node;
                    lock_tail  = next_slot(lock_tail);
                    lock_count = lock_count + CNT_W'(1);
                    if (lock_count == 1)
                        grant_new_head(r);
                end
            end
            CMD_RELEASE:
            begin
                if (lock_count == 0 || lock_queue[lock_head] != node)
                    r.status = STATUS_MISMATCH;
                else
                begin
                    lock_head  = next_slot(lock_head);
                    lock_count = lock_count - CNT_W'(1);
                    grant_new_head(r);
                end
            end
            CMD_TICK:
            begin
                if (outage_on && lock_count != 0)
                begin
                    head = lock_queue[lock_head];
                    // Same head as last time: count on, else start watching it
                    if (watch_valid && watch_node == head)
                    begin
                        if (stall_ticks != STALL_MAX)
                            stall_ticks = stall_ticks + STALL_W'(1);
                    end
                    else
                    begin
                        watch_valid = 1'b1;
                        watch_node  = head;
                        stall_ticks = '0;
                    end
                    if (stall_ticks == timeout_limit)
                    begin
                        r.evicted_valid  = 1'b1;
                        r.evicted_node   = head;
                        evictions_so_far = evictions_so_far + TOTAL_W'(1);
                        lock_head   = next_slot(lock_head);
                        lock_count  = lock_count - CNT_W'(1);
                        watch_valid = 1'b0;
                        stall_ticks = '0;
                        grant_new_head(r);
                    end
                end
            end
            default: ;
        endcase
        r.queue_count    = lock_count;
        r.admitted_total = grants_so_far;
        r.peak_queue     = peak_seen;
        r.failed_total   = evictions_so_far;
        pending_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one command beat, idling first at the phase rate; predict on acceptance
    task automatic send_beat(input flc_cmd_t cmd, input logic [NODE_W-1:0] node);
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= node;
        do @(posedge clk); while (!s_tready);
        predict_lock_step(cmd, node);
    endtask

    // Write one register and drop valid again so back-to-back writes stay clean
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_OUTAGE_ENABLE)
            outage_on = value[0];
        else
            timeout_limit = value;
        @(posedge clk);
    endtask

    // Stop offering, wait for every outstanding result, then settle
    task automatic drain_results();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 64'(pending_results.size()), 0);
    endtask

    // Receiver: random stalls at the phase rate, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
        begin
            m_tready      <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_start)
        begin
            m_tready      <= 1'b0;
            hold_off_left <= HOLD_OFF_CYCLES;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Compare every accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        lock_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing outstanding", 64'(m_tuser), 0);
            else
            begin
                want = pending_results.pop_front();
                check_field("grant_valid", 64'(m_tuser[0]), 64'(want.grant_valid));
                check_field("status", 64'(m_tuser[2:1]), 64'(want.status));
                check_field("evicted_valid", 64'(m_tuser[3]), 64'(want.evicted_valid));
                check_field("grant_node", 64'(m_tdata[NODE_W-1:0]), 64'(want.grant_node));
                check_field("evicted_node", 64'(m_tdata[EVICT_LSB +: NODE_W]),
                            64'(want.evicted_node));
                check_field("queue_count", 64'(m_tdata[COUNT_LSB +: CNT_W]),
                            64'(want.queue_count));
                check_field("admitted_total", 64'(m_tdata[ADMIT_LSB +: TOTAL_W]),
                            64'(want.admitted_total));
                check_field("peak_queue", 64'(m_tdata[PEAK_LSB +: CNT_W]),
                            64'(want.peak_queue));
                check_field("failed_total", 64'(m_tdata[FAIL_LSB +: TOTAL_W]),
                            64'(want.failed_total));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: empty-queue cases, unused command, grant on request and release,
    // non-head release, and eviction after the default timeout of eight ticks
    task automatic test_basic_grant_release();
        send_beat(CMD_RELEASE, 8'h5A);
        send_beat(CMD_NONE, 8'hA5);
        send_beat(CMD_TICK, 8'h33);
        send_beat(CMD_REQUEST, 8'h00);
        send_beat(CMD_REQUEST, 8'hFF);
        send_beat(CMD_RELEASE, 8'hFF);
        send_beat(CMD_RELEASE, 8'h00);
        repeat (9) send_beat(CMD_TICK, 8'hCC);
        drain_results();
    endtask

    // Shortest timeouts, a repeated id re-watched from zero, and ticks while disabled
    task automatic test_timeout_extremes();
        write_register(REG_TIMEOUT_TICKS, 8'd1);
        send_beat(CMD_REQUEST, 8'h3C);
        send_beat(CMD_REQUEST, 8'h3C);
        repeat (4) send_beat(CMD_TICK, 8'h00);
        drain_results();
        write_register(REG_TIMEOUT_TICKS, 8'd0);
        send_beat(CMD_REQUEST, 8'hC3);
        send_beat(CMD_TICK, 8'hFF);
        drain_results();
        write_register(REG_OUTAGE_ENABLE, 8'd0);
        send_beat(CMD_REQUEST, 8'h81);
        repeat (3) send_beat(CMD_TICK, 8'h81);
        send_beat(CMD_RELEASE, 8'h81);
        drain_results();
        write_register(REG_OUTAGE_ENABLE, 8'd1);
        write_register(REG_TIMEOUT_TICKS, TIMEOUT_RESET);
    endtask

    // Lower the timeout below the running count so the stall counter saturates,
    // then raise it to the top so the saturated count evicts
    task automatic test_stall_saturation();
        write_register(REG_TIMEOUT_TICKS, 8'd10);
        send_beat(CMD_REQUEST, 8'h42);
        repeat (5) send_beat(CMD_TICK, 8'h00);
        drain_results();
        write_register(REG_TIMEOUT_TICKS, 8'd3);
        repeat (260) send_beat(CMD_TICK, 8'h00);
        drain_results();
        write_register(REG_TIMEOUT_TICKS, 8'd255);
        send_beat(CMD_TICK, 8'h00);
        drain_results();
    endtask

    // Hold the receiver off so the block backs up and stalls its input, then
    // overfill the queue and empty it again
    task automatic test_backpressure_fill();
        write_register(REG_TIMEOUT_TICKS, TIMEOUT_RESET);
        hold_off_start <= 1'b1;
        @(posedge clk);
        hold_off_start <= 1'b0;
        repeat (DEPTH + 2) send_beat(CMD_REQUEST, NODE_W'($urandom_range(255)));
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i % 4 == 0)
                send_beat(CMD_RELEASE, ~lock_queue[lock_head]);
            send_beat(CMD_RELEASE, lock_queue[lock_head]);
        end
        drain_results();
    endtask

    // One random command: releases mostly name the real head, a small id
    // pool so the same node recurs, and some noise
    task automatic send_random_op();
        int pick;
        logic [NODE_W-1:0] node;
        pick = $urandom_range(99);
        if ($urandom_range(1) != 0)
            node = NODE_W'($urandom_range(3));
        else
            node = NODE_W'($urandom_range(255));
        if (pick < 38)
            send_beat(CMD_REQUEST, node);
        else if (pick < 68)
        begin
            if (lock_count != 0 && $urandom_range(99) < 75)
                node = lock_queue[lock_head];
            send_beat(CMD_RELEASE, node);
        end
        else if (pick < 96)
            send_beat(CMD_TICK, node);
        else
            send_beat(CMD_NONE, node);
    endtask

    task automatic test_random_traffic(input int idle, input int stall,
                                       input logic enable, input logic [7:0] timeout);
        idle_pct  = idle;
        stall_pct = stall;
        write_register(REG_OUTAGE_ENABLE, {7'd0, enable});
        write_register(REG_TIMEOUT_TICKS, timeout);
        repeat (PHASE_ITEMS) send_random_op();
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_grant_release();
        test_timeout_extremes();
        test_stall_saturation();
        test_backpressure_fill();

        test_random_traffic(0, 0, 1'b1, 8'd1);
        test_random_traffic(58, 0, 1'b1, STALL_W'($urandom_range(2, 6)));
        test_random_traffic(0, 58, 1'b1, 8'd255);
        test_random_traffic(32, 32, 1'b1, STALL_W'($urandom_range(1, 4)));

        drain_results();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #TIMEOUT_NS;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
